@@ hdl/ufrc_pkg.sv @@
package ufrc_pkg;

    localparam logic [7:0] START_BYTE_RESET = 8'h48;
    localparam logic [7:0] LEN_MIN          = 8'h06;
    localparam logic [7:0] LEN_MAX          = 8'hFE;
    localparam logic [7:0] HEADER_BYTES     = 8'h04;
    localparam logic [7:0] FRAME_OVERHEAD   = 8'h05;

    // Frame position codes
    localparam logic [7:0] POS_HUNT   = 8'd0;
    localparam logic [7:0] POS_LENGTH = 8'd1;
    localparam logic [7:0] POS_TYPE   = 8'd2;
    localparam logic [7:0] POS_IDENT  = 8'd3;
    localparam logic [7:0] POS_LEAD   = 8'd4;

    // Frame type codes
    localparam logic [7:0] TYPE_REPORT  = 8'h01;
    localparam logic [7:0] TYPE_COMMAND = 8'h02;
    localparam logic [7:0] TYPE_CONTROL = 8'hFE;
    localparam logic [7:0] TYPE_ERROR   = 8'hFF;

    // Known control codes
    localparam logic [7:0] CTRL_LOW_MIN = 8'h01;
    localparam logic [7:0] CTRL_LOW_MAX = 8'h06;
    localparam logic [7:0] CTRL_10      = 8'h10;
    localparam logic [7:0] CTRL_11      = 8'h11;
    localparam logic [7:0] CTRL_20      = 8'h20;
    localparam logic [7:0] CTRL_21      = 8'h21;

    // Frame status codes
    localparam logic [1:0] STATUS_GOOD        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM     = 2'd1;
    localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd2;

    // Frame class codes
    localparam logic [2:0] CLASS_REPORT       = 3'd0;
    localparam logic [2:0] CLASS_COMMAND      = 3'd1;
    localparam logic [2:0] CLASS_CONTROL      = 3'd2;
    localparam logic [2:0] CLASS_ERROR        = 3'd3;
    localparam logic [2:0] CLASS_UNSUP_TYPE   = 3'd4;
    localparam logic [2:0] CLASS_UNSUP_CTRL   = 3'd5;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       frame_end;
        logic [1:0] frame_status;
        logic [2:0] frame_class;
        logic [7:0] type_code;
        logic [7:0] ident;
        logic [7:0] lead_payload;
        logic [7:0] payload_count;
        logic       error_reply_due;
    } t_result;

    function automatic logic [2:0] classify(input logic [7:0] type_byte,
                                            input logic [7:0] lead);
        logic known;
        known = (lead >= CTRL_LOW_MIN && lead <= CTRL_LOW_MAX) ||
                lead == CTRL_10 || lead == CTRL_11 ||
                lead == CTRL_20 || lead == CTRL_21;
        case (type_byte)
            TYPE_REPORT:  classify = CLASS_REPORT;
            TYPE_COMMAND: classify = CLASS_COMMAND;
            TYPE_CONTROL: classify = known ? CLASS_CONTROL : CLASS_UNSUP_CTRL;
            TYPE_ERROR:   classify = CLASS_ERROR;
            default:      classify = CLASS_UNSUP_TYPE;
        endcase
    endfunction

endpackage

@@ hdl/ufrc_in_reg.sv @@
module ufrc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_in_stall,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_load;

    // Load a new item when empty or when the held one moves on this cycle
    assign n_load     = !r_valid || i_take;
    assign o_in_stall = !n_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hdl/ufrc_parser.sv @@
module ufrc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_start_byte,
    output ufrc_pkg::t_result   o_result
);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_type, n_type;
    logic [7:0] r_ident, n_ident;
    logic [7:0] r_lead, n_lead;
    logic       good;
    ufrc_pkg::t_result res;

    assign good = (i_byte == r_sum);

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_type  = r_type;
        n_ident = r_ident;
        n_lead  = r_lead;
        res     = '0;
        if (r_pos == ufrc_pkg::POS_HUNT) begin
            if (i_byte == i_start_byte) begin
                n_sum = i_byte;
                n_pos = ufrc_pkg::POS_LENGTH;
            end
        end else if (r_pos == ufrc_pkg::POS_LENGTH) begin
            if (i_byte < ufrc_pkg::LEN_MIN || i_byte > ufrc_pkg::LEN_MAX) begin
                n_pos            = ufrc_pkg::POS_HUNT;
                res.frame_end    = 1'b1;
                res.frame_status = ufrc_pkg::STATUS_BAD_LENGTH;
            end else begin
                n_len = i_byte;
                n_sum = r_sum + i_byte;
                n_pos = ufrc_pkg::POS_TYPE;
            end
        end else if (r_pos >= r_len || r_len < ufrc_pkg::LEN_MIN) begin
            // inconsistent state: drop back to hunting
            n_pos = ufrc_pkg::POS_HUNT;
        end else if (r_pos == r_len - 8'd1) begin
            res.frame_end       = 1'b1;
            res.frame_status    = good ? ufrc_pkg::STATUS_GOOD : ufrc_pkg::STATUS_BAD_SUM;
            res.frame_class     = good ? ufrc_pkg::classify(r_type, r_lead)
                                       : ufrc_pkg::CLASS_REPORT;
            res.type_code       = r_type;
            res.ident           = r_ident;
            res.lead_payload    = r_lead;
            res.payload_count   = r_len - ufrc_pkg::FRAME_OVERHEAD;
            res.error_reply_due = !good;
            n_pos               = ufrc_pkg::POS_HUNT;
        end else begin
            if (r_pos == ufrc_pkg::POS_TYPE) begin
                n_type = i_byte;
            end else if (r_pos == ufrc_pkg::POS_IDENT) begin
                n_ident = i_byte;
            end else begin
                if (r_pos == ufrc_pkg::POS_LEAD) begin
                    n_lead = i_byte;
                end
                res.data_valid = 1'b1;
                res.data_byte  = i_byte;
                res.data_index = r_pos - ufrc_pkg::HEADER_BYTES;
            end
            n_sum = r_sum + i_byte;
            n_pos = r_pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= ufrc_pkg::POS_HUNT;
            r_len   <= '0;
            r_sum   <= '0;
            r_type  <= '0;
            r_ident <= '0;
            r_lead  <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_type  <= n_type;
            r_ident <= n_ident;
            r_lead  <= n_lead;
        end
    end

    assign o_result = res;

endmodule

@@ hdl/ufrc_out_reg.sv @@
module ufrc_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ufrc_pkg::t_result   i_result,
    input  logic                i_out_stall,
    output logic                o_ready,
    output logic                o_out_valid,
    output ufrc_pkg::t_result   o_result
);

    logic              r_valid;
    ufrc_pkg::t_result r_result;

    // Free when empty or when the held item is taken this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

@@ hdl/uart_frame_receiver_checksum_top.sv @@
// Frame receiver for a byte serial link with an 8-bit additive checksum. One received
// byte goes in per item and exactly one result item comes out for it, in order. Items
// are accepted one per cycle while the result side does not stall. Each byte passes
// through the input register, then the parse and checksum logic into the result
// register, and stall on the result side only backs up through these two registers.
// The start byte register may be written only while no item is in flight.
module uart_frame_receiver_checksum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_data_valid,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_data_index,
    output logic       o_frame_end,
    output logic [1:0] o_frame_status,
    output logic [2:0] o_frame_class,
    output logic [7:0] o_type_code,
    output logic [7:0] o_ident,
    output logic [7:0] o_lead_payload,
    output logic [7:0] o_payload_count,
    output logic       o_error_reply_due
);

    logic [7:0]        r_start;
    logic              stage_valid;
    logic [7:0]        stage_byte;
    logic              out_ready;
    logic              fire;
    ufrc_pkg::t_result step_result;
    ufrc_pkg::t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= ufrc_pkg::START_BYTE_RESET;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_data;
        end
    end

    assign fire = stage_valid && out_ready;

    ufrc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_take     (out_ready),
        .o_valid    (stage_valid),
        .o_byte     (stage_byte)
    );

    ufrc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (stage_byte),
        .i_start_byte (r_start),
        .o_result     (step_result)
    );

    ufrc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_result    (step_result),
        .i_out_stall (i_out_stall),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_data_valid      = out_result.data_valid;
    assign o_data_byte       = out_result.data_byte;
    assign o_data_index      = out_result.data_index;
    assign o_frame_end       = out_result.frame_end;
    assign o_frame_status    = out_result.frame_status;
    assign o_frame_class     = out_result.frame_class;
    assign o_type_code       = out_result.type_code;
    assign o_ident           = out_result.ident;
    assign o_lead_payload    = out_result.lead_payload;
    assign o_payload_count   = out_result.payload_count;
    assign o_error_reply_due = out_result.error_reply_due;

endmodule

@@ tb/frame_result_checker.sv @@
`timescale 1ns / 100ps

module frame_result_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  ufrc_pkg::t_result i_seen,
    output int                o_pending,
    output int                o_fail_count
);

    logic [7:0] start_copy = ufrc_pkg::START_BYTE_RESET;
    logic [7:0] pos        = ufrc_pkg::POS_HUNT;
    logic [7:0] flen       = 8'h00;
    logic [7:0] sum        = 8'h00;
    logic [7:0] type_held  = 8'h00;
    logic [7:0] ident_held = 8'h00;
    logic [7:0] lead_held  = 8'h00;

    ufrc_pkg::t_result due_results[$];
    ufrc_pkg::t_result want;
    int      pending_count = 0;
    int      fail_count    = 0;

    assign o_pending    = pending_count;
    assign o_fail_count = fail_count;

    function automatic logic [2:0] frame_kind(input logic [7:0] kind, input logic [7:0] lead);
        logic known_code;
        known_code = (lead >= ufrc_pkg::CTRL_LOW_MIN && lead <= ufrc_pkg::CTRL_LOW_MAX) ||
                     lead == ufrc_pkg::CTRL_10 || lead == ufrc_pkg::CTRL_11 ||
                     lead == ufrc_pkg::CTRL_20 || lead == ufrc_pkg::CTRL_21;
        if (kind == ufrc_pkg::TYPE_REPORT)
            return ufrc_pkg::CLASS_REPORT;
        if (kind == ufrc_pkg::TYPE_COMMAND)
            return ufrc_pkg::CLASS_COMMAND;
        if (kind == ufrc_pkg::TYPE_ERROR)
            return ufrc_pkg::CLASS_ERROR;
        if (kind == ufrc_pkg::TYPE_CONTROL)
            return known_code ? ufrc_pkg::CLASS_CONTROL : ufrc_pkg::CLASS_UNSUP_CTRL;
        return ufrc_pkg::CLASS_UNSUP_TYPE;
    endfunction

    // Advance the frame parser by one byte and return the result item it causes.
    function automatic ufrc_pkg::t_result parse_byte(input logic [7:0] b);
        ufrc_pkg::t_result r;
        r = '0;
        if (pos == ufrc_pkg::POS_HUNT) begin
            if (b == start_copy) begin
                sum = b;
                pos = ufrc_pkg::POS_LENGTH;
            end
        end else if (pos == ufrc_pkg::POS_LENGTH) begin
            if (b < ufrc_pkg::LEN_MIN || b > ufrc_pkg::LEN_MAX) begin
                pos            = ufrc_pkg::POS_HUNT;
                r.frame_end    = 1'b1;
                r.frame_status = ufrc_pkg::STATUS_BAD_LENGTH;
            end else begin
                flen = b;
                sum  = sum + b;
                pos  = ufrc_pkg::POS_TYPE;
            end
        end else if (pos >= flen || flen < ufrc_pkg::LEN_MIN) begin
            pos = ufrc_pkg::POS_HUNT;
        end else if (pos == flen - 8'd1) begin
            r.frame_end       = 1'b1;
            r.frame_status    = (b == sum) ? ufrc_pkg::STATUS_GOOD : ufrc_pkg::STATUS_BAD_SUM;
            r.frame_class     = (b == sum) ? frame_kind(type_held, lead_held)
                                           : ufrc_pkg::CLASS_REPORT;
            r.type_code       = type_held;
            r.ident           = ident_held;
            r.lead_payload    = lead_held;
            r.payload_count   = flen - ufrc_pkg::FRAME_OVERHEAD;
            r.error_reply_due = (b != sum);
            pos               = ufrc_pkg::POS_HUNT;
        end else begin
            if (pos == ufrc_pkg::POS_TYPE) begin
                type_held = b;
            end else if (pos == ufrc_pkg::POS_IDENT) begin
                ident_held = b;
            end else begin
                if (pos == ufrc_pkg::POS_LEAD)
                    lead_held = b;
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = pos - ufrc_pkg::HEADER_BYTES;
            end
            sum = sum + b;
            pos = pos + 8'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_copy = ufrc_pkg::START_BYTE_RESET;
            pos        = ufrc_pkg::POS_HUNT;
            flen       = 8'h00;
            sum        = 8'h00;
            type_held  = 8'h00;
            ident_held = 8'h00;
            lead_held  = 8'h00;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result item with no input item pending");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("data_valid", 8'(want.data_valid), 8'(i_seen.data_valid));
                    check_field("data_byte", want.data_byte, i_seen.data_byte);
                    check_field("data_index", want.data_index, i_seen.data_index);
                    check_field("frame_end", 8'(want.frame_end), 8'(i_seen.frame_end));
                    check_field("frame_status", 8'(want.frame_status),
                                8'(i_seen.frame_status));
                    check_field("frame_class", 8'(want.frame_class),
                                8'(i_seen.frame_class));
                    check_field("type_code", want.type_code, i_seen.type_code);
                    check_field("ident", want.ident, i_seen.ident);
                    check_field("lead_payload", want.lead_payload, i_seen.lead_payload);
                    check_field("payload_count", want.payload_count, i_seen.payload_count);
                    check_field("error_reply_due", 8'(want.error_reply_due),
                                8'(i_seen.error_reply_due));
                end
            end
            if (i_cfg_we)
                start_copy = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                due_results = {due_results, parse_byte(i_rx_byte)};
        end
        pending_count = due_results.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 315;
    localparam int NUM_PHASES  = 6;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;

    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [2:0] frame_class;
    logic [7:0] type_code;
    logic [7:0] ident;
    logic [7:0] lead_payload;
    logic [7:0] payload_count;
    logic       error_reply_due;
    ufrc_pkg::t_result seen;

    int         pending;
    int         fail_count;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         phase_items    = 0;
    int         cycle_count    = 0;
    logic [7:0] cur_start      = ufrc_pkg::START_BYTE_RESET;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uart_frame_receiver_checksum_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_data_valid      (data_valid),
        .o_data_byte       (data_byte),
        .o_data_index      (data_index),
        .o_frame_end       (frame_end),
        .o_frame_status    (frame_status),
        .o_frame_class     (frame_class),
        .o_type_code       (type_code),
        .o_ident           (ident),
        .o_lead_payload    (lead_payload),
        .o_payload_count   (payload_count),
        .o_error_reply_due (error_reply_due)
    );

    assign seen = {data_valid, data_byte, data_index, frame_end, frame_status, frame_class,
                   type_code, ident, lead_payload, payload_count, error_reply_due};

    frame_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_seen       (seen),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Enter and leave at a falling edge; valid stays high for a back-to-back item.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        phase_items++;
    endtask

    // Send a frame with random payload after the lead byte; drop the last cut bytes.
    task automatic push_frame(input logic [7:0] len, input logic [7:0] kind,
                              input logic [7:0] id, input logic [7:0] lead,
                              input bit good_sum, input int cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        frame_bytes = {cur_start, len, kind, id, lead};
        for (int i = ufrc_pkg::LEN_MIN; i < len; i++)
            frame_bytes = {frame_bytes, 8'($urandom)};
        sum = 8'h00;
        foreach (frame_bytes[i])
            sum = sum + frame_bytes[i];
        frame_bytes = {frame_bytes, good_sum ? sum : sum + 8'($urandom_range(1, 255))};
        for (int i = 0; i < frame_bytes.size() - cut; i++)
            push_byte(frame_bytes[i]);
    endtask

    task automatic random_traffic();
        int         pick;
        logic [7:0] len;
        logic [7:0] kind;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = 8'($urandom_range(ufrc_pkg::LEN_MIN, 10));
        else if (pick < 97)
            len = 8'($urandom_range(11, 40));
        else
            len = 8'($urandom_range(41, ufrc_pkg::LEN_MAX));
        case ($urandom_range(0, 5))
            0:       kind = ufrc_pkg::TYPE_REPORT;
            1:       kind = ufrc_pkg::TYPE_COMMAND;
            2, 3:    kind = ufrc_pkg::TYPE_CONTROL;
            4:       kind = ufrc_pkg::TYPE_ERROR;
            default: kind = 8'($urandom);
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            lead = 8'($urandom_range(ufrc_pkg::CTRL_LOW_MIN, ufrc_pkg::CTRL_LOW_MAX));
        end else if (pick < 7) begin
            case ($urandom_range(0, 3))
                0:       lead = ufrc_pkg::CTRL_10;
                1:       lead = ufrc_pkg::CTRL_11;
                2:       lead = ufrc_pkg::CTRL_20;
                default: lead = ufrc_pkg::CTRL_21;
            endcase
        end else begin
            lead = 8'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            push_frame(len, kind, 8'($urandom), lead, $urandom_range(0, 99) < 85, 0);
        end else if (pick < 82) begin
            push_byte(cur_start);
            if ($urandom_range(0, 1))
                push_byte(8'($urandom_range(0, ufrc_pkg::LEN_MIN - 1)));
            else
                push_byte(ufrc_pkg::LEN_MAX + 8'd1);
        end else if (pick < 90) begin
            // truncated frame: the following bytes are swallowed as frame data
            push_frame(len, kind, 8'($urandom), lead, 1'b1, $urandom_range(1, len - 1));
        end else begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_start(input logic [7:0] value);
        drain();
        repeat (4)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        cur_start = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            case (p)
                1: load_start(8'h00);
                2: load_start(8'hFF);
                3: load_start(8'($urandom));
                4: load_start(ufrc_pkg::START_BYTE_RESET);
                5: load_start(8'($urandom));
                default: ;
            endcase
            phase_items = 0;
            if (p == 0) begin
                push_byte(~cur_start);
                push_byte(cur_start);
                push_byte(ufrc_pkg::LEN_MIN - 8'd1);
                push_byte(cur_start);
                push_byte(ufrc_pkg::LEN_MAX + 8'd1);
                push_frame(ufrc_pkg::LEN_MIN, ufrc_pkg::TYPE_CONTROL, 8'h00,
                           ufrc_pkg::CTRL_21, 1'b1, 0);
                // start byte as frame type, bad checksum
                push_frame(ufrc_pkg::LEN_MIN, cur_start, 8'hFF, 8'h00, 1'b0, 0);
                push_frame(ufrc_pkg::LEN_MIN, ufrc_pkg::TYPE_ERROR, 8'h5A, 8'hFF, 1'b1, 0);
            end
            if (p == 2)
                push_frame(ufrc_pkg::LEN_MAX, ufrc_pkg::TYPE_COMMAND, 8'($urandom),
                           8'($urandom), 1'b1, 0);
            while (phase_items < PHASE_ITEMS)
                random_traffic();
        end

        drain();
        repeat (8)
            @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
